@@ rtl/polynomial_gradient_descent_assert.svh @@
// Assertion macros shared by the polynomial gradient descent checkers.
`ifndef POLYNOMIAL_GRADIENT_DESCENT_ASSERT_SVH
`define POLYNOMIAL_GRADIENT_DESCENT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define PGD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("polynomial_gradient_descent: assertion failed");

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define PGD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("polynomial_gradient_descent: assertion failed");

`endif

@@ rtl/pgd_pkg.sv @@
// Types, constants and helper functions of the polynomial gradient descent block.
package pgd_pkg;

  localparam int MAX_DEGREE  = 8;
  localparam int STORE_DEPTH = MAX_DEGREE + 1;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int TERM_W      = 32 + IDX_W;
  localparam int SUM_W       = TERM_W + 1;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLY_DEGREE     = 2'd0,
    REG_STEP_RATE       = 2'd1,
    REG_SLOPE_TOLERANCE = 2'd2,
    REG_ITERATION_LIMIT = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_RUN  = 1'b1
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_D_MUL,
    S_D_ADD,
    S_CHECK,
    S_STEP_MUL,
    S_STEP_ADD,
    S_V_MUL,
    S_V_ADD,
    S_OUT
  } state_e;

  typedef struct packed {
    logic               mode;
    logic [3:0]         coeff_index;
    logic signed [31:0] coeff_value;
    logic signed [31:0] start_x;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] final_x;
    logic signed [31:0] final_value;
    logic [19:0]        steps_taken;
    logic               converged;
  } out_item_t;

  typedef struct packed {
    logic mul_en;
    logic subtract;
  } mac_ctrl_t;

  // Clamps a signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat_q(logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

@@ rtl/pgd_mac.sv @@
// Shared multiply, floor shift, saturate and accumulate unit.
module pgd_mac (
  input  logic                              clk_i,
  input  pgd_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [31:0]                mul_a_i,
  input  logic signed [31:0]                mul_b_i,
  input  logic signed [pgd_pkg::TERM_W-1:0] addend_i,
  output logic signed [31:0]                result_o
);
  import pgd_pkg::*;

  logic signed [63:0]      prod_q;
  logic signed [31:0]      scaled;
  logic signed [SUM_W-1:0] sum;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= mul_a_i * mul_b_i;
    end
  end

  // An arithmetic shift of the exact product is a floor division by 2^16.
  assign scaled = sat_q(prod_q >>> 16);

  always_comb begin
    if (ctrl_i.subtract) begin
      sum = SUM_W'(addend_i) - SUM_W'(scaled);
    end else begin
      sum = SUM_W'(addend_i) + SUM_W'(scaled);
    end
  end

  assign result_o = sat_q(64'(sum));

endmodule

@@ rtl/polynomial_gradient_descent.sv @@
// Top level of the polynomial gradient descent block: store, sequencer and ports.
//
// A load beat writes one coefficient without leaving the idle state; loads to powers above the
// degree bound are dropped. Every coefficient up to the degree in use must be loaded before a
// run. A run beat starts a descent from start_x and yields one result beat. The Horner terms
// and the update steps of a run pass through one shared 32 by 32 multiplier followed by a
// saturating adder, each term as a multiply state and then an add state. A run also waits for
// the previous result beat to be taken. The input is not ready while a run is in progress.
module polynomial_gradient_descent (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  pgd_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pgd_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pgd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [31:0]                         cfg_data_i
);
  import pgd_pkg::*;

  state_e state_q, state_d;

  logic [3:0]  poly_degree_q;
  logic [30:0] step_rate_q;
  logic [30:0] slope_tol_q;
  logic [19:0] iter_limit_q;

  logic signed [31:0]       coef_q  [STORE_DEPTH];
  logic signed [TERM_W-1:0] dcoef_q [STORE_DEPTH];
  logic signed [TERM_W-1:0] rd_q;

  logic signed [31:0] acc_q;
  logic signed [31:0] x_q;
  logic [IDX_W-1:0]   idx_q;
  logic [19:0]        steps_q;
  logic               conv_q;
  logic               out_valid_q;
  out_item_t          out_data_q;

  logic [IDX_W-1:0]         deg_use;
  logic [IDX_W-1:0]         load_idx;
  logic                     load_ok;
  logic signed [TERM_W-1:0] dterm;
  logic [32:0]              slope_mag;
  logic                     slope_ok;
  logic                     in_fire;
  logic                     out_load;

  mac_ctrl_t                mac_ctrl;
  logic signed [31:0]       mul_a;
  logic signed [31:0]       mul_b;
  logic signed [TERM_W-1:0] addend;
  logic signed [31:0]       mac_res;

  pgd_mac u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .mul_a_i  (mul_a),
    .mul_b_i  (mul_b),
    .addend_i (addend),
    .result_o (mac_res)
  );

  always_comb begin
    if (poly_degree_q == 4'd0) begin
      deg_use = IDX_W'(1);
    end else if (int'(poly_degree_q) > MAX_DEGREE) begin
      deg_use = IDX_W'(MAX_DEGREE);
    end else begin
      deg_use = IDX_W'(poly_degree_q);
    end
  end

  assign in_fire  = in_valid_i && in_ready_o;
  assign load_idx = IDX_W'(in_data_i.coeff_index);
  assign load_ok  = int'(in_data_i.coeff_index) <= MAX_DEGREE;
  assign dterm    = TERM_W'(in_data_i.coeff_value) * TERM_W'($signed({1'b0, load_idx}));

  assign slope_mag = acc_q[31] ? (33'd0 - 33'(acc_q)) : 33'(acc_q);
  assign slope_ok  = slope_mag <= {2'b00, slope_tol_q};
  assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && in_data_i.mode == MODE_RUN) begin
          state_d = S_D_MUL;
        end
      end
      S_D_MUL:    state_d = S_D_ADD;
      S_D_ADD: begin
        state_d = (idx_q == IDX_W'(1)) ? S_CHECK : S_D_MUL;
      end
      S_CHECK: begin
        state_d = (slope_ok || steps_q >= iter_limit_q) ? S_V_MUL : S_STEP_MUL;
      end
      S_STEP_MUL: state_d = S_STEP_ADD;
      S_STEP_ADD: state_d = S_D_MUL;
      S_V_MUL:    state_d = S_V_ADD;
      S_V_ADD: begin
        state_d = (idx_q == '0) ? S_OUT : S_V_MUL;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = (state_q == S_IDLE);
    mac_ctrl.mul_en   = (state_q == S_D_MUL) || (state_q == S_V_MUL) ||
                        (state_q == S_STEP_MUL);
    mac_ctrl.subtract = (state_q == S_STEP_ADD);
    if (state_q == S_STEP_MUL) begin
      mul_a = signed'({1'b0, step_rate_q});
      mul_b = acc_q;
    end else begin
      mul_a = acc_q;
      mul_b = x_q;
    end
    addend = (state_q == S_STEP_ADD) ? TERM_W'(x_q) : rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      poly_degree_q <= 4'd1;
      step_rate_q   <= 31'd6554;
      slope_tol_q   <= 31'd66;
      iter_limit_q  <= 20'd1000;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_POLY_DEGREE:     poly_degree_q <= cfg_data_i[3:0];
          REG_STEP_RATE:       step_rate_q   <= cfg_data_i[30:0];
          REG_SLOPE_TOLERANCE: slope_tol_q   <= cfg_data_i[30:0];
          REG_ITERATION_LIMIT: iter_limit_q  <= cfg_data_i[19:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.mode == MODE_LOAD && load_ok) begin
      coef_q[load_idx]  <= in_data_i.coeff_value;
      dcoef_q[load_idx] <= dterm;
    end
    if (state_q == S_D_MUL) begin
      rd_q <= dcoef_q[idx_q];
    end else if (state_q == S_V_MUL) begin
      rd_q <= TERM_W'(coef_q[idx_q]);
    end
    if (out_load) begin
      out_data_q.final_x     <= x_q;
      out_data_q.final_value <= acc_q;
      out_data_q.steps_taken <= steps_q;
      out_data_q.converged   <= conv_q;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && in_data_i.mode == MODE_RUN) begin
          x_q     <= in_data_i.start_x;
          steps_q <= '0;
          conv_q  <= 1'b0;
          acc_q   <= '0;
          idx_q   <= deg_use;
        end
      end
      S_D_ADD, S_V_ADD: begin
        acc_q <= mac_res;
        idx_q <= idx_q - IDX_W'(1);
      end
      S_CHECK: begin
        conv_q <= slope_ok;
        if (slope_ok || steps_q >= iter_limit_q) begin
          acc_q <= '0;
          idx_q <= deg_use;
        end
      end
      S_STEP_ADD: begin
        x_q     <= mac_res;
        steps_q <= steps_q + 20'd1;
        acc_q   <= '0;
        idx_q   <= deg_use;
      end
      S_D_MUL, S_V_MUL, S_STEP_MUL, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/pgd_checker.sv @@
// Port-level checker for the polynomial gradient descent block, bound to its top level.
`include "polynomial_gradient_descent_assert.svh"

module pgd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input pgd_pkg::in_item_t             in_data_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input pgd_pkg::out_item_t            out_data_o
);
  import pgd_pkg::*;

  // A result beat that is not taken stays offered and unchanged.
  `PGD_ASSERT_NEXT(a_out_valid_holds, out_valid_o && !out_ready_i, out_valid_o)
  `PGD_ASSERT_NEXT(a_out_data_holds, out_valid_o && !out_ready_i, $stable(out_data_o))

  // A load beat finishes at once; a run beat occupies the block.
  `PGD_ASSERT_NEXT(a_load_keeps_ready, in_valid_i && in_ready_o && in_data_i.mode == MODE_LOAD,
                   in_ready_o)
  `PGD_ASSERT_NEXT(a_run_blocks_input, in_valid_i && in_ready_o && in_data_i.mode == MODE_RUN,
                   !in_ready_o)

  // A new result appears only at the end of a run.
  `PGD_ASSERT_NOW(a_result_after_run, $rose(out_valid_o), $past(!in_ready_o))

endmodule

bind polynomial_gradient_descent pgd_checker u_pgd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ bench/tb_polynomial_gradient_descent.sv @@
// Self-checking testbench for the polynomial gradient descent block, with its scoreboard class.

class descent_scoreboard;
  longint              coeff_store [0:pgd_pkg::MAX_DEGREE];
  logic [3:0]          degree_reg;
  logic [30:0]         rate_reg;
  logic [30:0]         tol_reg;
  logic [19:0]         limit_reg;
  pgd_pkg::out_item_t  pending_results [$];
  int unsigned         mismatches;

  function new();
    foreach (coeff_store[i]) coeff_store[i] = 0;
    degree_reg  = 4'd1;
    rate_reg    = 31'd6554;
    tol_reg     = 31'd66;
    limit_reg   = 20'd1000;
    mismatches  = 0;
  endfunction

  function void write_reg(pgd_pkg::cfg_reg_e idx, logic [31:0] data);
    case (idx)
      pgd_pkg::REG_POLY_DEGREE:     degree_reg = data[3:0];
      pgd_pkg::REG_STEP_RATE:       rate_reg   = data[30:0];
      pgd_pkg::REG_SLOPE_TOLERANCE: tol_reg    = data[30:0];
      pgd_pkg::REG_ITERATION_LIMIT: limit_reg  = data[19:0];
      default: ;
    endcase
  endfunction

  function longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Exact product, floor shift by the fraction width, then clamp.
  function longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return sat32(p >>> 16);
  endfunction

  function int used_degree();
    int d;
    d = int'(degree_reg);
    if (d < 1) d = 1;
    if (d > pgd_pkg::MAX_DEGREE) d = pgd_pkg::MAX_DEGREE;
    return d;
  endfunction

  function longint slope_at(longint x);
    longint acc;
    int     i;
    acc = 0;
    for (i = used_degree(); i >= 1; i--) begin
      acc = sat32(qmul(acc, x) + longint'(i) * coeff_store[i]);
    end
    return acc;
  endfunction

  function longint value_at(longint x);
    longint acc;
    int     i;
    acc = 0;
    for (i = used_degree(); i >= 0; i--) begin
      acc = sat32(qmul(acc, x) + coeff_store[i]);
    end
    return acc;
  endfunction

  function bit within_tol(longint slope);
    longint mag;
    mag = (slope < 0) ? -slope : slope;
    return mag <= longint'(tol_reg);
  endfunction

  function pgd_pkg::out_item_t predict_run(logic [31:0] start);
    longint             x;
    longint             slope;
    longint             fx;
    int unsigned        steps;
    bit                 conv;
    pgd_pkg::out_item_t res;
    x     = longint'($signed(start));
    steps = 0;
    conv  = 1'b0;
    while (steps < limit_reg) begin
      slope = slope_at(x);
      if (within_tol(slope)) begin
        conv = 1'b1;
        break;
      end
      x = sat32(x - qmul(longint'(rate_reg), slope));
      steps++;
    end
    if (within_tol(slope_at(x))) conv = 1'b1;
    fx                = value_at(x);
    res.final_x       = x[31:0];
    res.final_value   = fx[31:0];
    res.steps_taken   = steps[19:0];
    res.converged     = conv;
    return res;
  endfunction

  function void note_input(pgd_pkg::in_item_t it);
    if (it.mode == pgd_pkg::MODE_LOAD) begin
      if (int'(it.coeff_index) <= pgd_pkg::MAX_DEGREE) begin
        coeff_store[it.coeff_index] = longint'($signed(it.coeff_value));
      end
    end else begin
      pending_results.push_back(predict_run(it.start_x));
    end
  endfunction

  function void check_result(pgd_pkg::out_item_t got);
    pgd_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      $error("result beat with no run outstanding: final_x %0d", $signed(got.final_x));
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (got.final_x !== want.final_x) begin
      $error("final_x: expected %0d, got %0d", $signed(want.final_x), $signed(got.final_x));
      mismatches++;
    end
    if (got.final_value !== want.final_value) begin
      $error("final_value: expected %0d, got %0d",
             $signed(want.final_value), $signed(got.final_value));
      mismatches++;
    end
    if (got.steps_taken !== want.steps_taken) begin
      $error("steps_taken: expected %0d, got %0d", want.steps_taken, got.steps_taken);
      mismatches++;
    end
    if (got.converged !== want.converged) begin
      $error("converged: expected %0b, got %0b", want.converged, got.converged);
      mismatches++;
    end
  endfunction
endclass

module tb_polynomial_gradient_descent;
  timeunit 1ns;
  timeprecision 1ps;

  import pgd_pkg::*;

  localparam int unsigned ITEM_TARGET   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 50;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_EVERY_FOURTH,
    RX_SPARSE
  } rx_pattern_e;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [31:0]           cfg_data  = '0;

  descent_scoreboard     descent_sb = new();
  int unsigned           items_sent = 0;
  int unsigned           burst_left = 0;
  rx_pattern_e           rx_mode    = RX_ALWAYS;
  int unsigned           rx_left    = 0;
  int unsigned           rx_phase   = 0;

  polynomial_gradient_descent dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_pattern_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    rx_phase++;
    case (rx_mode)
      RX_ALWAYS:       out_ready = 1'b1;
      RX_COIN:         out_ready = 1'($urandom_range(0, 1));
      RX_EVERY_FOURTH: out_ready = (rx_phase % 4 == 0);
      default:         out_ready = ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      descent_sb.check_result(out_data);
    end
  end

  initial begin
    #25ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [31:0] pick_q();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 32'h7ffff)) - 32'h3ffff);
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h00000000;
          default: return 32'hffffffff;
        endcase
      end
      default: return 32'(int'($urandom_range(0, 32'hffffff)) - 32'h7fffff);
    endcase
  endfunction

  function automatic logic [31:0] pick_mag();
    case ($urandom_range(0, 6))
      0: return 32'd0;
      1: return 32'h7fffffff;
      2: return $urandom;
      3: return $urandom & 32'h7fffffff;
      default: return $urandom_range(1, 32'h10000);
    endcase
  endfunction

  // Expects to be called at a falling edge and returns at one.
  task automatic send_item(in_item_t it);
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    descent_sb.note_input(it);
    if (!(it.mode == MODE_LOAD && int'(it.coeff_index) > MAX_DEGREE)) items_sent++;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic load_coeff(int unsigned idx, logic [31:0] value);
    in_item_t it;
    it.mode        = MODE_LOAD;
    it.coeff_index = idx[3:0];
    it.coeff_value = value;
    it.start_x     = $urandom;
    send_item(it);
  endtask

  task automatic run_from(logic [31:0] x);
    in_item_t it;
    it.mode        = MODE_RUN;
    it.coeff_index = 4'($urandom_range(0, 15));
    it.coeff_value = $urandom;
    it.start_x     = x;
    send_item(it);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (descent_sb.pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    descent_sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic directed_checks();
    int unsigned i;
    // Every coefficient is written first, so no run ever reads an unwritten entry.
    load_coeff(0, 32'h7fffffff);
    load_coeff(1, 32'h80000000);
    for (i = 2; i <= MAX_DEGREE; i++) begin
      load_coeff(i, 32'(int'($urandom_range(0, 32'h7ffff)) - 32'h3ffff));
    end
    load_coeff(9, 32'h12345678);
    load_coeff(15, 32'hffffffff);
    run_from(32'h00000000);
    run_from(32'h80000000);
    load_coeff(1, 32'h00000000);
    run_from(32'h7fffffff);
    load_coeff(1, 32'h00010000);
    drain();
    write_reg(REG_ITERATION_LIMIT, 32'd0);
    run_from(32'h00030000);
    drain();
    write_reg(REG_ITERATION_LIMIT, 32'd5);
    write_reg(REG_STEP_RATE, 32'd0);
    run_from(32'hfffd0000);
    drain();
    write_reg(REG_POLY_DEGREE, 32'd0);
    write_reg(REG_SLOPE_TOLERANCE, 32'd0);
    write_reg(REG_STEP_RATE, 32'hffffffff);
    run_from(32'h00020000);
    load_coeff(1, 32'h00000000);
    run_from(32'h00050000);
    drain();
    // The derivative at zero is the linear coefficient, which is zero, so the run ends at once.
    write_reg(REG_POLY_DEGREE, 32'hffffffff);
    write_reg(REG_ITERATION_LIMIT, 32'hffffffff);
    write_reg(REG_SLOPE_TOLERANCE, 32'h7fffffff);
    run_from(32'h00000000);
    drain();
    write_reg(REG_POLY_DEGREE, 32'd8);
    write_reg(REG_ITERATION_LIMIT, 32'd1);
    run_from(32'h00010000);
  endtask

  task automatic random_phase();
    bit          tame;
    int unsigned count;
    int unsigned i;
    drain();
    tame = 1'($urandom_range(0, 1));
    if (tame) begin
      write_reg(REG_POLY_DEGREE, $urandom_range(2, MAX_DEGREE));
      write_reg(REG_STEP_RATE, $urandom_range(1000, 20000));
      write_reg(REG_SLOPE_TOLERANCE, $urandom_range(16, 4096));
      write_reg(REG_ITERATION_LIMIT, $urandom_range(1, 40));
      load_coeff(0, pick_q());
      load_coeff(1, 32'(int'($urandom_range(0, 32'h3ffff)) - 32'h1ffff));
      load_coeff(2, $urandom_range(32'h4000, 32'h20000));
      for (i = 3; i <= MAX_DEGREE; i++) begin
        if ($urandom_range(0, 1) == 0) begin
          load_coeff(i, 32'd0);
        end else begin
          load_coeff(i, 32'(int'($urandom_range(0, 32'hfff)) - 32'h7ff));
        end
      end
    end else begin
      write_reg(REG_POLY_DEGREE, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 8));
      write_reg(REG_STEP_RATE, pick_mag());
      write_reg(REG_SLOPE_TOLERANCE, pick_mag());
      write_reg(REG_ITERATION_LIMIT, $urandom_range(0, 40));
    end
    count = $urandom_range(15, 35);
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) drain();
      if (tame) begin
        if ($urandom_range(0, 6) == 0) begin
          load_coeff($urandom_range(0, MAX_DEGREE),
                     32'(int'($urandom_range(0, 32'h3ffff)) - 32'h1ffff));
        end else begin
          run_from(32'(int'($urandom_range(0, 32'h80000)) - 32'h40000));
        end
      end else begin
        if ($urandom_range(0, 9) < 3) begin
          load_coeff($urandom_range(0, 15), pick_q());
        end else begin
          run_from(pick_q());
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    directed_checks();
    while (items_sent < ITEM_TARGET) random_phase();
    in_valid = 1'b0;
    while (descent_sb.pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (descent_sb.mismatches == 0 && descent_sb.pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
